FILE: rtl/core/lkvc_pkg.sv
// Shared constants, types and state encoding of the LRU key-value cache.
package lkvc_pkg;

   localparam int DEF_MAX_ENTRIES = 16;
   localparam int DEF_KEY_BITS    = 32;
   localparam int KEY_PORT_BITS   = 32;
   localparam int VALUE_BITS      = 32;
   localparam int CAP_BITS        = 5;

   localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_SET = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_EVICT,
      ST_COMMIT
   } engine_state_type;

   typedef struct packed {
      logic                          hit;
      logic signed [VALUE_BITS-1:0]  value;
   } rsp_type;

endpackage

FILE: rtl/core/lru_key_value_cache_core.sv
// LRU key-value cache: get/set items in through a queue, get results out through a queue.
// The engine takes an item, matches its key across all entries, then commits the
// recency/value update and takes the next; a get's commit waits while the result
// queue is full, and a set of a new key into a full store first evicts the least
// recently used entries, normally one. Two-entry queues in front of and behind the
// engine keep intake and result draining independent of it. A get yields one result
// (hit and value, or zero on miss); a set yields none. Reset clears the store. The user
// must write csr_wdata (capacity, clamped to 1..MAX_ENTRIES) while idle; not enforced.
module lru_key_value_cache_core #(
   parameter int MAX_ENTRIES = lkvc_pkg::DEF_MAX_ENTRIES,
   parameter int KEY_BITS    = lkvc_pkg::DEF_KEY_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_push,
   output logic                                    req_full,
   input  logic                                    req_func,
   input  logic [lkvc_pkg::KEY_PORT_BITS-1:0]      req_lookup_key,
   input  logic signed [lkvc_pkg::VALUE_BITS-1:0]  req_store_value,
   output logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   output logic                                    rsp_hit,
   output logic signed [lkvc_pkg::VALUE_BITS-1:0]  rsp_read_value,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [lkvc_pkg::CAP_BITS-1:0]           csr_wdata
);
   import lkvc_pkg::*;

   localparam int KeyW = (KEY_BITS < KEY_PORT_BITS) ? KEY_BITS : KEY_PORT_BITS;
   localparam int ReqW = 1 + KeyW + VALUE_BITS;
   localparam int RspW = $bits(rsp_type);

   logic [CAP_BITS-1:0] capacity_ff, capacity_in;

   logic [ReqW-1:0] req_word, item_word;
   logic            item_empty, item_pop;
   logic            item_is_set;
   logic [KeyW-1:0] item_key;
   logic signed [VALUE_BITS-1:0] item_value;

   rsp_type         eng_rsp, out_rsp;
   logic [RspW-1:0] out_word;
   logic            eng_push, rsp_q_full;

   assign csr_ready   = 1'b1;
   assign capacity_in = (csr_valid && csr_ready) ? csr_wdata : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // Classify at intake: set flag, key cut to its matching width, value.
   assign req_word = {(req_func == FUNC_SET), req_lookup_key[KeyW-1:0], req_store_value};

   lkvc_fifo #(.WIDTH(ReqW)) u_req_q (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .full    (req_full),
      .wr_data (req_word),
      .pop     (item_pop),
      .empty   (item_empty),
      .rd_data (item_word)
   );

   assign item_is_set = item_word[ReqW-1];
   assign item_key    = item_word[ReqW-2:VALUE_BITS];
   assign item_value  = item_word[VALUE_BITS-1:0];

   lkvc_engine #(.MAX_ENTRIES(MAX_ENTRIES), .KEY_W(KeyW)) u_engine (
      .clock       (clock),
      .reset       (reset),
      .capacity    (capacity_ff),
      .item_valid  (!item_empty),
      .item_pop    (item_pop),
      .item_is_set (item_is_set),
      .item_key    (item_key),
      .item_value  (item_value),
      .rsp_push    (eng_push),
      .rsp_full    (rsp_q_full),
      .rsp_data    (eng_rsp)
   );

   lkvc_fifo #(.WIDTH(RspW)) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (eng_push),
      .full    (rsp_q_full),
      .wr_data (eng_rsp),
      .pop     (rsp_pop),
      .empty   (rsp_empty),
      .rd_data (out_word)
   );

   assign out_rsp        = out_word;
   assign rsp_hit        = out_rsp.hit;
   assign rsp_read_value = out_rsp.value;

endmodule

FILE: rtl/core/lkvc_fifo.sv
// Two-entry queue that decouples neighboring stages.
module lkvc_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] slots_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign rd_data = slots_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: rtl/core/lkvc_engine.sv
// Back end: key match, LRU eviction and recency update over the entry store.
module lkvc_engine #(
   parameter int MAX_ENTRIES = lkvc_pkg::DEF_MAX_ENTRIES,
   parameter int KEY_W       = lkvc_pkg::DEF_KEY_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [lkvc_pkg::CAP_BITS-1:0]       capacity,
   input  logic                                item_valid,
   output logic                                item_pop,
   input  logic                                item_is_set,
   input  logic [KEY_W-1:0]                    item_key,
   input  logic signed [lkvc_pkg::VALUE_BITS-1:0] item_value,
   output logic                                rsp_push,
   input  logic                                rsp_full,
   output lkvc_pkg::rsp_type                   rsp_data
);
   import lkvc_pkg::*;

   localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CntW = $clog2(MAX_ENTRIES + 1);
   localparam int CmpW = (CntW > CAP_BITS) ? CntW : CAP_BITS;

   engine_state_type state_ff, state_in;

   logic                          is_set_ff, is_set_in;
   logic [KEY_W-1:0]              key_ff, key_in;
   logic signed [VALUE_BITS-1:0]  value_ff, value_in;
   logic                          hit_ff, hit_in;
   logic [IdxW-1:0]               hit_idx_ff, hit_idx_in;
   logic [IdxW-1:0]               hit_rank_ff, hit_rank_in;

   logic [MAX_ENTRIES-1:0]        valid_ff, valid_in;
   logic [KEY_W-1:0]              keys_ff   [MAX_ENTRIES];
   logic [KEY_W-1:0]              keys_in   [MAX_ENTRIES];
   logic signed [VALUE_BITS-1:0]  values_ff [MAX_ENTRIES];
   logic signed [VALUE_BITS-1:0]  values_in [MAX_ENTRIES];
   logic [IdxW-1:0]               ranks_ff  [MAX_ENTRIES];
   logic [IdxW-1:0]               ranks_in  [MAX_ENTRIES];
   logic [CntW-1:0]               occ_ff, occ_in;

   logic [MAX_ENTRIES-1:0]        match_vec;
   logic [MAX_ENTRIES-1:0]        victim_vec;
   logic [IdxW-1:0]               match_idx;
   logic [IdxW-1:0]               free_idx;
   logic [CmpW-1:0]               live_cap;
   logic [CmpW-1:0]               occ_ext;
   logic                          need_evict;
   logic                          still_evict;
   logic                          commit_go;

   // Clamp capacity to 1..MAX_ENTRIES.
   always_comb begin
      if (capacity == '0) begin
         live_cap = CmpW'(1);
      end else if (CmpW'(capacity) > CmpW'(MAX_ENTRIES)) begin
         live_cap = CmpW'(MAX_ENTRIES);
      end else begin
         live_cap = CmpW'(capacity);
      end
   end

   assign occ_ext     = CmpW'(occ_ff);
   assign need_evict  = (occ_ext >= live_cap);
   assign still_evict = ((occ_ext - CmpW'(1)) >= live_cap);

   always_comb begin
      match_idx = '0;
      free_idx  = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match_vec[i]  = valid_ff[i] && (keys_ff[i] == key_ff);
         victim_vec[i] = valid_ff[i] && ((CntW'(ranks_ff[i]) + CntW'(1)) == occ_ff);
      end
      // Lowest index wins.
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            match_idx = IdxW'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IdxW'(i);
         end
      end
   end

   assign commit_go = (state_ff == ST_COMMIT) && !(!is_set_ff && rsp_full);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            if (is_set_ff && (match_vec == '0) && need_evict) begin
               state_in = ST_EVICT;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_EVICT: begin
            if (!still_evict) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (commit_go) begin
               state_in = item_valid ? ST_MATCH : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      item_pop = item_valid && ((state_ff == ST_IDLE) || commit_go);
      rsp_push = commit_go && !is_set_ff;
      rsp_data.hit   = hit_ff;
      rsp_data.value = hit_ff ? values_ff[hit_idx_ff] : '0;
   end

   // Item latch and match capture.
   always_comb begin
      is_set_in   = is_set_ff;
      key_in      = key_ff;
      value_in    = value_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_rank_in = hit_rank_ff;
      if (item_pop) begin
         is_set_in = item_is_set;
         key_in    = item_key;
         value_in  = item_value;
      end
      if (state_ff == ST_MATCH) begin
         hit_in      = (match_vec != '0);
         hit_idx_in  = match_idx;
         hit_rank_in = ranks_ff[match_idx];
      end
   end

   // Entry store update.
   always_comb begin
      valid_in  = valid_ff;
      keys_in   = keys_ff;
      values_in = values_ff;
      ranks_in  = ranks_ff;
      occ_in    = occ_ff;
      if (state_ff == ST_EVICT) begin
         valid_in = valid_ff & ~victim_vec;
         occ_in   = occ_ff - CntW'(1);
      end else if (commit_go) begin
         if (hit_ff) begin
            // Touch: entries newer than the hit age by one.
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (valid_ff[i] && (ranks_ff[i] < hit_rank_ff)) begin
                  ranks_in[i] = ranks_ff[i] + IdxW'(1);
               end
            end
            ranks_in[hit_idx_ff] = '0;
            if (is_set_ff) begin
               values_in[hit_idx_ff] = value_ff;
            end
         end else if (is_set_ff) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (valid_ff[i]) begin
                  ranks_in[i] = ranks_ff[i] + IdxW'(1);
               end
            end
            valid_in[free_idx]  = 1'b1;
            keys_in[free_idx]   = key_ff;
            values_in[free_idx] = value_ff;
            ranks_in[free_idx]  = '0;
            occ_in              = occ_ff + CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         occ_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      is_set_ff   <= is_set_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_rank_ff <= hit_rank_in;
      keys_ff     <= keys_in;
      values_ff   <= values_in;
      ranks_ff    <= ranks_in;
   end

`ifndef SYNTHESIS
   occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(occ_ff))
      else $error("occupancy differs from number of valid entries");

   occ_bounded: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CntW'(MAX_ENTRIES))
      else $error("occupancy above entry count");

   one_victim: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVICT) |-> $onehot(victim_vec))
      else $error("eviction without a single least recently used entry");

   unique_keys: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MATCH) |-> $onehot0(match_vec))
      else $error("key present in more than one entry");

   insert_has_room: assert property (@(posedge clock) disable iff (reset)
      (commit_go && is_set_ff && !hit_ff) |-> (valid_ff != '1))
      else $error("insert with no free entry");
`endif

endmodule

FILE: dv/lru_key_value_cache_core_tb.sv
// Self-checking testbench of the LRU key-value cache core: directed table, then random phases.
module lru_key_value_cache_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lkvc_pkg::*;

   localparam int NUM_SLOTS     = DEF_MAX_ENTRIES;
   localparam int CLK_HALF      = 6;
   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int NUM_PHASES    = 12;
   localparam int PHASE_ITEMS   = 96;
   localparam int KEY_POOL_SIZE = 32;

   typedef enum logic [1:0] {
      ROW_GET,
      ROW_SET,
      ROW_CAP
   } row_kind_type;

   typedef struct packed {
      row_kind_type                kind;
      logic [KEY_PORT_BITS-1:0]    key;
      logic [VALUE_BITS-1:0]       data;
      logic                        fixed;
      logic                        hit;
      logic [VALUE_BITS-1:0]       read_data;
   } dir_row_type;

   localparam int NUM_ROWS = 23;
   localparam dir_row_type DIRECTED [NUM_ROWS] = '{
      '{ROW_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      '{ROW_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
      '{ROW_SET, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},
      '{ROW_SET, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{ROW_GET, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b1, 32'h7FFF_FFFF},
      '{ROW_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
      '{ROW_SET, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0000_0000},
      '{ROW_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
      '{ROW_SET, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, 32'h0000_0000},
      '{ROW_SET, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0000_0000},
      '{ROW_GET, 32'h1234_5678, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
      // shrink below occupancy: old entries stay until the next insertion
      '{ROW_CAP, 32'h0000_0000, 32'd2,         1'b0, 1'b0, 32'h0000_0000},
      '{ROW_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{ROW_SET, 32'h0000_0000, 32'h0000_0001, 1'b0, 1'b0, 32'h0000_0000},
      '{ROW_SET, 32'h0000_0001, 32'h0000_0002, 1'b0, 1'b0, 32'h0000_0000},
      '{ROW_GET, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{ROW_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      // zero capacity acts as one entry
      '{ROW_CAP, 32'h0000_0000, 32'd0,         1'b0, 1'b0, 32'h0000_0000},
      '{ROW_SET, 32'h0000_0002, 32'h0000_0003, 1'b0, 1'b0, 32'h0000_0000},
      '{ROW_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      '{ROW_GET, 32'h0000_0002, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
      // above the slot count clamps to the slot count
      '{ROW_CAP, 32'h0000_0000, 32'd31,        1'b0, 1'b0, 32'h0000_0000},
      '{ROW_GET, 32'h0000_0002, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000}
   };

   localparam logic [CAP_BITS-1:0] CAP_PLAN [NUM_PHASES] = '{
      5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd4, 5'd2, 5'd8, 5'd15, 5'd3, 5'd16, 5'd5
   };

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_push = 1'b0;
   logic                          req_full;
   logic                          req_func = FUNC_GET;
   logic [KEY_PORT_BITS-1:0]      req_lookup_key = '0;
   logic signed [VALUE_BITS-1:0]  req_store_value = '0;
   logic                          rsp_empty;
   logic                          rsp_pop = 1'b0;
   logic                          rsp_hit;
   logic signed [VALUE_BITS-1:0]  rsp_read_value;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CAP_BITS-1:0]           csr_wdata = '0;

   lru_key_value_cache_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_func        (req_func),
      .req_lookup_key  (req_lookup_key),
      .req_store_value (req_store_value),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   // shadow copy of the store
   logic [KEY_PORT_BITS-1:0]  shadow_key   [NUM_SLOTS];
   logic [VALUE_BITS-1:0]     shadow_value [NUM_SLOTS];
   bit                        shadow_valid [NUM_SLOTS];
   int unsigned               shadow_rank  [NUM_SLOTS];
   int unsigned               shadow_occ;
   logic [CAP_BITS-1:0]       shadow_cap;

   rsp_type                   pending_reads [$];
   logic [KEY_PORT_BITS-1:0]  key_pool [KEY_POOL_SIZE];
   int                        tx_idle_pct = 16;
   int                        rx_idle_pct = 51;
   int                        mismatches  = 0;
   int                        cycle_count = 0;

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int lru_find(logic [KEY_PORT_BITS-1:0] k);
      for (int i = 0; i < NUM_SLOTS; i++)
         if (shadow_valid[i] && shadow_key[i] == k)
            return i;
      return -1;
   endfunction

   // move slot s to the front; entries newer than it age by one
   function automatic void lru_touch(int s);
      int unsigned r;
      r = shadow_rank[s];
      for (int i = 0; i < NUM_SLOTS; i++)
         if (shadow_valid[i] && shadow_rank[i] < r)
            shadow_rank[i]++;
      shadow_rank[s] = 0;
   endfunction

   function automatic void lru_evict_oldest();
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (shadow_valid[i] && shadow_rank[i] + 1 == shadow_occ) begin
            shadow_valid[i] = 1'b0;
            shadow_key[i]   = '0;
            shadow_value[i] = '0;
            shadow_rank[i]  = 0;
            shadow_occ--;
            return;
         end
      end
   endfunction

   function automatic void lru_insert(logic [KEY_PORT_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
      int          slot;
      int unsigned cap_eff;
      slot = -1;
      if (shadow_cap == 0)
         cap_eff = 1;
      else if (shadow_cap > NUM_SLOTS)
         cap_eff = NUM_SLOTS;
      else
         cap_eff = shadow_cap;
      while (shadow_occ >= cap_eff && shadow_occ > 0)
         lru_evict_oldest();
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (!shadow_valid[i]) begin
            if (slot < 0)
               slot = i;
         end else begin
            shadow_rank[i]++;
         end
      end
      shadow_valid[slot] = 1'b1;
      shadow_key[slot]   = k;
      shadow_value[slot] = v;
      shadow_rank[slot]  = 0;
      shadow_occ++;
   endfunction

   // apply one item to the shadow store; returns 1 when a get produces a read
   function automatic bit lru_apply(logic f, logic [KEY_PORT_BITS-1:0] k,
                                    logic [VALUE_BITS-1:0] v, output rsp_type rd);
      int s;
      s  = lru_find(k);
      rd = '0;
      if (f == FUNC_SET) begin
         if (s >= 0) begin
            shadow_value[s] = v;
            lru_touch(s);
         end else begin
            lru_insert(k, v);
         end
         return 1'b0;
      end
      if (s >= 0) begin
         lru_touch(s);
         rd.hit   = 1'b1;
         rd.value = shadow_value[s];
      end
      return 1'b1;
   endfunction

   task automatic send_op(logic f, logic [KEY_PORT_BITS-1:0] k, logic [VALUE_BITS-1:0] v,
                          bit fixed, rsp_type fixed_rsp);
      rsp_type rd;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push        <= 1'b1;
      req_func        <= f;
      req_lookup_key  <= k;
      req_store_value <= v;
      do @(posedge clock); while (req_full);
      if (lru_apply(f, k, v, rd))
         pending_reads.push_back(fixed ? fixed_rsp : rd);
   endtask

   // drain, let trailing sets finish, then transfer the new capacity
   task automatic write_capacity(logic [CAP_BITS-1:0] c);
      req_push <= 1'b0;
      while (pending_reads.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= c;
      do @(posedge clock); while (!csr_ready);
      shadow_cap = c;
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_reads.size() == 0) begin
               $display("%0t: read with none pending: hit=%0b value=%h",
                        $realtime, rsp_hit, rsp_read_value);
               mismatches++;
            end else begin
               want = pending_reads.pop_front();
               if (rsp_hit !== want.hit) begin
                  $display("%0t: hit expected %0b actual %0b",
                           $realtime, want.hit, rsp_hit);
                  mismatches++;
               end
               if (rsp_read_value !== want.value) begin
                  $display("%0t: read_value expected %h actual %h",
                           $realtime, want.value, rsp_read_value);
                  mismatches++;
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   initial begin
      rsp_type                   fixed_rsp;
      logic                      f;
      logic [KEY_PORT_BITS-1:0]  k;
      int                        span;

      for (int i = 0; i < NUM_SLOTS; i++) begin
         shadow_key[i]   = '0;
         shadow_value[i] = '0;
         shadow_valid[i] = 1'b0;
         shadow_rank[i]  = 0;
      end
      shadow_occ = 0;
      shadow_cap = CAP_RESET;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL_SIZE; i++)
         key_pool[i] = $urandom;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[r]) begin
         if (DIRECTED[r].kind == ROW_CAP) begin
            write_capacity(DIRECTED[r].data[CAP_BITS-1:0]);
         end else begin
            fixed_rsp.hit   = DIRECTED[r].hit;
            fixed_rsp.value = DIRECTED[r].read_data;
            send_op((DIRECTED[r].kind == ROW_SET) ? FUNC_SET : FUNC_GET,
                    DIRECTED[r].key, DIRECTED[r].data, DIRECTED[r].fixed, fixed_rsp);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_capacity(CAP_PLAN[p]);
         case (p / 4)
            0: begin
               tx_idle_pct = 16;
               rx_idle_pct = 51;
            end
            1: begin
               tx_idle_pct = 51;
               rx_idle_pct = 16;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         // a pool of 4 to 24 keys, used for most items, keeps both hits and evictions frequent
         span = $urandom_range(4, 24);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            f = $urandom_range(1) ? FUNC_SET : FUNC_GET;
            if ($urandom_range(9) < 8)
               k = key_pool[$urandom_range(span - 1)];
            else
               k = $urandom;
            send_op(f, k, $urandom, 1'b0, '0);
         end
      end

      req_push <= 1'b0;
      while (pending_reads.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: lru_key_value_cache_core.f
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_fifo.sv
rtl/core/lkvc_engine.sv
rtl/core/lru_key_value_cache_core.sv
dv/lru_key_value_cache_core_tb.sv
